// ----- rtl/core/rrsb_pkg.sv -----
`timescale 1ns / 1ps

package rrsb_pkg;

    localparam int SET_IN_W     = 11;
    localparam int WAY_IN_W     = 4;
    localparam int ADDR_W       = 64;
    localparam int LINE_OFS     = 6;
    localparam int BLK_W        = ADDR_W - LINE_OFS;
    localparam int DEFAULT_SETS = 2048;
    localparam int DEFAULT_WAYS = 16;

    localparam logic       ACT_VICTIM = 1'b0;
    localparam logic       ACT_UPDATE = 1'b1;
    localparam logic [1:0] RRPV_DIST  = 2'd3;
    localparam logic [1:0] RRPV_NEAR  = 2'd0;
    localparam logic [1:0] RRPV_MID   = 2'd1;
    localparam logic [1:0] REUSE_SAT  = 2'd3;

    typedef struct packed {
        logic                    action;
        logic [SET_IN_W-1:0]     set_index;
        logic [WAY_IN_W-1:0]     way;
        logic                    hit;
        logic [ADDR_W-1:0]       address;
    } in_item_t;

    typedef struct packed {
        logic [WAY_IN_W-1:0]     victim_way;
        logic                    bypassed;
        logic                    set_streaming;
    } out_item_t;

    // way modulo a small way count by conditional subtraction
    function automatic logic [WAY_IN_W:0] way_wrap(logic [WAY_IN_W-1:0] w, int ways);
        logic [WAY_IN_W:0] r;
        int                step;
        r = (WAY_IN_W + 1)'(w);
        for (int k = WAY_IN_W - 1; k >= 0; k--)
        begin
            step = ways << k;
            if (step <= int'(r))
            begin
                r = r - (WAY_IN_W + 1)'(step);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/rrsb_set_map.sv -----
`timescale 1ns / 1ps

// set_index mod SETS by reciprocal multiply; quotient registered, remainder next cycle
module rrsb_set_map #(
    parameter int SETS   = rrsb_pkg::DEFAULT_SETS,
    parameter int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic                          clk,
    input  logic                          load,
    input  logic [rrsb_pkg::SET_IN_W-1:0] set_index,
    output logic [SIDX_W-1:0]             set_sel
);

    localparam int    N     = rrsb_pkg::SET_IN_W;
    localparam int    LG    = $clog2(SETS);
    localparam int    SH    = N + LG;
    localparam longint RECIP = ((64'sd1 <<< SH) + longint'(SETS) - 1) / longint'(SETS);
    localparam int    RCP_W = N + 2;
    localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);
    localparam logic [31:0]      SETS_C  = 32'(SETS);

    logic [N-1:0]         x_reg;
    logic [N-1:0]         q_reg;
    logic [N+RCP_W-1:0]   prod;
    logic [31:0]          back;
    logic [31:0]          rem;

    assign prod = (N + RCP_W)'(set_index) * (N + RCP_W)'(RECIP_C);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= set_index;
            q_reg <= N'(prod >> SH);
        end
    end

    assign back    = 32'(q_reg) * SETS_C;
    assign rem     = 32'(x_reg) - back;
    assign set_sel = rem[SIDX_W-1:0];

endmodule

// ----- rtl/core/rrsb_row_mem.sv -----
`timescale 1ns / 1ps

// one row per set, synchronous read with registered data
module rrsb_row_mem #(
    parameter int SETS   = rrsb_pkg::DEFAULT_SETS,
    parameter int ROW_W  = 8,
    parameter int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [SIDX_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [SIDX_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data
);

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rrsb_row_update.sv -----
`timescale 1ns / 1ps

// Row layout, LSB first: rrpv[WAYS], reuse[WAYS], newer block, last miss delta, stream flag.
// The stored delta is the previous miss's d1, which equals newer - older.
module rrsb_row_update #(
    parameter int WAYS   = rrsb_pkg::DEFAULT_WAYS,
    parameter int WIDX_W = $clog2(WAYS),
    parameter int ROW_W  = 4 * WAYS + 2 * rrsb_pkg::BLK_W + 1
) (
    input  logic [ROW_W-1:0]    row_in,
    input  rrsb_pkg::in_item_t  item,
    input  logic [WIDX_W-1:0]   way_sel,
    output logic [ROW_W-1:0]    row_out,
    output rrsb_pkg::out_item_t res
);

    localparam int BW      = rrsb_pkg::BLK_W;
    localparam int REUSE_O = 2 * WAYS;
    localparam int NEWER_O = 4 * WAYS;
    localparam int DELTA_O = NEWER_O + BW;
    localparam int FLAG_O  = DELTA_O + BW;
    localparam logic [BW-1:0] D_P1 = BW'(1);
    localparam logic [BW-1:0] D_P2 = BW'(2);
    localparam logic [BW-1:0] D_M1 = {BW{1'b1}};
    localparam logic [BW-1:0] D_M2 = {BW{1'b1}} - BW'(1);

    logic [1:0]        rrpv   [WAYS];
    logic [1:0]        reuse  [WAYS];
    logic [WAYS-1:0]   at3, at2up, nonzero, match, first;
    logic [1:0]        top, age;
    logic [WIDX_W-1:0] vidx;
    logic [WIDX_W+3:0] vidx_ext;
    logic [BW-1:0]     newer, last_delta, blk, d1;
    logic              flag, streaming;
    logic [1:0]        r_sel;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            rrpv[w]    = row_in[2*w +: 2];
            reuse[w]   = row_in[REUSE_O + 2*w +: 2];
            at3[w]     = rrpv[w] == rrsb_pkg::RRPV_DIST;
            at2up[w]   = rrpv[w][1];
            nonzero[w] = rrpv[w] != 2'd0;
        end
        newer      = row_in[NEWER_O +: BW];
        last_delta = row_in[DELTA_O +: BW];
        flag       = row_in[FLAG_O];
        blk        = item.address[rrsb_pkg::LINE_OFS +: BW];

        // largest rrpv in the set; aging by 3 - top lifts the ways holding it to 3
        top = (|at3) ? 2'd3 : (|at2up) ? 2'd2 : (|nonzero) ? 2'd1 : 2'd0;
        age = rrsb_pkg::RRPV_DIST - top;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = rrpv[w] == top;
        end
        first = match & (~match + WAYS'(1));
        vidx  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (first[w])
            begin
                vidx = vidx | WIDX_W'(w);
            end
        end
        vidx_ext = {4'd0, vidx};

        d1        = (newer != '0) ? (blk - newer) : '0;
        streaming = (d1 == last_delta)
                    && (d1 == D_P1 || d1 == D_P2 || d1 == D_M1 || d1 == D_M2);
        r_sel     = reuse[way_sel];

        row_out           = row_in;
        res.victim_way    = '0;
        res.bypassed      = 1'b0;
        res.set_streaming = flag;

        if (item.action == rrsb_pkg::ACT_VICTIM)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                row_out[2*w +: 2] = rrpv[w] + age;
            end
            res.victim_way = vidx_ext[3:0];
        end
        else if (item.hit)
        begin
            if (r_sel != rrsb_pkg::REUSE_SAT)
            begin
                row_out[REUSE_O + 2*way_sel +: 2] = r_sel + 2'd1;
            end
            row_out[2*way_sel +: 2] = rrsb_pkg::RRPV_NEAR;
        end
        else
        begin
            row_out[NEWER_O +: BW] = blk;
            row_out[DELTA_O +: BW] = d1;
            row_out[FLAG_O]        = streaming;
            res.set_streaming      = streaming;
            if (streaming)
            begin
                row_out[2*way_sel +: 2] = rrsb_pkg::RRPV_DIST;
                res.bypassed            = 1'b1;
            end
            else
            begin
                row_out[2*way_sel +: 2] = r_sel[1] ? rrsb_pkg::RRPV_NEAR :
                                          r_sel[0] ? rrsb_pkg::RRPV_MID : rrsb_pkg::RRPV_DIST;
                row_out[REUSE_O + 2*way_sel +: 2] = 2'd0;
            end
        end
    end

endmodule

// ----- rtl/core/rrip_replacement_stream_bypass_core.sv -----
`timescale 1ns / 1ps

// channel   ports                 handshake
// --------  --------------------  -----------------------------------------
// command   item (in_item_t)      taken at clk edge with start && !busy
// result    result (out_item_t)   valid for one cycle while done is high
//
// An item goes through set index mapping, then the row read; the row is
// modified and written back in the read-data cycle, when the next item may start.
// Result and done are registered from the read-data state. The set row memory's single
// read-modify-write per item sets the rate.
// After reset a clearing pass zeroes every row of the memory with busy high.
// The receiver cannot stall; results are never held.
module rrip_replacement_stream_bypass_core #(
    parameter int SETS = rrsb_pkg::DEFAULT_SETS,
    parameter int WAYS = rrsb_pkg::DEFAULT_WAYS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rrsb_pkg::in_item_t  item,
    output logic                done,
    output rrsb_pkg::out_item_t result
);

    localparam int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WIDX_W = $clog2(WAYS);
    localparam int ROW_W  = 4 * WAYS + 2 * rrsb_pkg::BLK_W + 1;
    localparam logic [SIDX_W-1:0] LAST_SET = SIDX_W'(SETS - 1);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_IDX  = 2'd2;
    localparam logic [1:0] ST_RD   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SIDX_W-1:0]   clr_reg, clr_next;
    logic [SIDX_W-1:0]   set_reg;
    logic [WIDX_W-1:0]   way_reg;
    rrsb_pkg::in_item_t  item_reg;
    logic                done_reg, done_next;
    rrsb_pkg::out_item_t result_reg;
    logic                accept;
    logic [SIDX_W-1:0]   set_sel;
    logic [ROW_W-1:0]    rd_data, row_new;
    logic                wr_en;
    logic [SIDX_W-1:0]   wr_addr;
    logic [ROW_W-1:0]    wr_data;
    rrsb_pkg::out_item_t res;
    logic [rrsb_pkg::WAY_IN_W:0] way_mod;

    assign busy   = (state_reg == ST_CLR) || (state_reg == ST_IDX);
    assign accept = start && !busy;

    rrsb_set_map #(
        .SETS   (SETS),
        .SIDX_W (SIDX_W)
    ) u_set_map (
        .clk       (clk),
        .load      (accept),
        .set_index (item.set_index),
        .set_sel   (set_sel)
    );

    rrsb_row_mem #(
        .SETS   (SETS),
        .ROW_W  (ROW_W),
        .SIDX_W (SIDX_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (state_reg == ST_IDX),
        .rd_addr (set_sel),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rrsb_row_update #(
        .WAYS   (WAYS),
        .WIDX_W (WIDX_W),
        .ROW_W  (ROW_W)
    ) u_row_update (
        .row_in  (rd_data),
        .item    (item_reg),
        .way_sel (way_reg),
        .row_out (row_new),
        .res     (res)
    );

    assign way_mod = rrsb_pkg::way_wrap(item.way, WAYS);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = set_reg;
        wr_data    = row_new;
        unique case (state_reg)
            ST_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + SIDX_W'(1);
                if (clr_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_IDX;
                end
            end
            ST_IDX:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                wr_en      = 1'b1;
                done_next  = 1'b1;
                state_next = accept ? ST_IDX : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            way_reg  <= way_mod[WIDX_W-1:0];
        end
        if (state_reg == ST_IDX)
        begin
            set_reg <= set_sel;
        end
        if (state_reg == ST_RD)
        begin
            result_reg <= res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
